/* hw/rtl/swr_pkg.sv */
// package for the stop-and-wait receiver with crc-32 packet check
// holds field widths, op codes and the crc-32 helper functions
// no dependencies
`default_nettype none

package swr_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int OFFSET_W  = 31;
    localparam int LEN_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 32;

    localparam int MAX_PAYLOAD = 1024;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // header bits fed into the crc: offset word then length word
    localparam int HDR_BITS = 64;

    // word kinds
    typedef enum logic [OP_W-1:0] {
        OP_HEADER  = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_TRAILER = 2'd2
    } t_op;

    typedef logic [CRC_W-1:0][HDR_BITS-1:0] t_hdr_rows;

    // one byte through the reflected crc, bit per step
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

    // crc of eight zero bytes from the all-ones start
    function automatic logic [CRC_W-1:0] hdr_base();
        logic [CRC_W-1:0] c;
        c = CRC_INIT;
        for (int k = 0; k < HDR_BITS / BYTE_W; k++) begin
            c = crc_byte(c, '0);
        end
        return c;
    endfunction

    // xor masks: which header bits reach each crc bit (zero start)
    function automatic t_hdr_rows hdr_rows();
        t_hdr_rows        rows;
        logic [CRC_W-1:0] c;
        logic [HDR_BITS-1:0] d;
        rows = '0;
        for (int i = 0; i < HDR_BITS; i++) begin
            c = '0;
            d = HDR_BITS'(1) << i;
            for (int k = 0; k < HDR_BITS / BYTE_W; k++) begin
                c = crc_byte(c, d[BYTE_W*k +: BYTE_W]);
            end
            for (int j = 0; j < CRC_W; j++) begin
                rows[j][i] = c[j];
            end
        end
        return rows;
    endfunction

    localparam logic [CRC_W-1:0] HDR_BASE = hdr_base();
    localparam t_hdr_rows        HDR_ROWS = hdr_rows();

    // crc after a header: one flat xor per crc bit
    function automatic logic [CRC_W-1:0] crc_header(input logic [OFFSET_W-1:0] offset,
                                                    input logic [LEN_W-1:0] len);
        logic [HDR_BITS-1:0] d;
        logic [CRC_W-1:0]    c;
        d = {21'd0, len, 1'b0, offset};
        for (int j = 0; j < CRC_W; j++) begin
            c[j] = HDR_BASE[j] ^ (^(d & HDR_ROWS[j]));
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/swr_if.sv */
// valid/ready channels for the receiver: input words and result words
// depends on swr_pkg
`default_nettype none

interface swr_in_if;
    import swr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [OFFSET_W-1:0] seq_offset;
    logic [LEN_W-1:0]    payload_len;
    logic                last_flag;
    logic [BYTE_W-1:0]   data_byte;
    logic [CRC_W-1:0]    crc_value;

    modport source (output valid, op, seq_offset, payload_len, last_flag, data_byte,
                    crc_value, input ready);
    modport sink   (input valid, op, seq_offset, payload_len, last_flag, data_byte,
                    crc_value, output ready);
endinterface

interface swr_out_if;
    import swr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] ack_offset;
    logic                accepted;
    logic                transfer_done;

    modport source (output valid, ack_offset, accepted, transfer_done, input ready);
    modport sink   (input valid, ack_offset, accepted, transfer_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stop_wait_receiver_crc32_check_core.sv */
// stop-and-wait receiver: checks packet crc-32, offset and length, emits acks
// a trailer word passes through the input register and then the result register
// throughput: one word per cycle while no trailer stalls; the byte crc step and
// the flat header xor are combinational between the input register and the state
// a trailer stalls only while the result register is full and not taken
// reset (synchronous, active low) empties both registers, count zero, crc all ones
`default_nettype none

module stop_wait_receiver_crc32_check_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    swr_in_if.sink      i_in,
    swr_out_if.source   o_out
);
    import swr_pkg::*;

    // input register
    logic                r_in_valid;
    logic [OP_W-1:0]     r_in_op;
    logic [OFFSET_W-1:0] r_in_offset;
    logic [LEN_W-1:0]    r_in_len;
    logic                r_in_last;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [CRC_W-1:0]    r_in_crc;

    // packet state; r_expect holds received count plus one
    logic [OFFSET_W-1:0] r_expect,   n_expect;
    logic [CRC_W-1:0]    r_crc,      n_crc;
    logic [OFFSET_W-1:0] r_hdr_offset, n_hdr_offset;
    logic [LEN_W-1:0]    r_hdr_len,  n_hdr_len;
    logic                r_hdr_last, n_hdr_last;
    logic [LEN_W-1:0]    r_count,    n_count;

    // result register
    logic                r_out_valid;
    logic [OFFSET_W-1:0] r_out_ack;
    logic                r_out_ok;
    logic                r_out_done;

    logic             advance;
    logic             is_trailer;
    logic             pkt_ok;
    logic [CRC_W-1:0] fin_crc;

    // the held word moves on unless it is a trailer facing a full result
    assign is_trailer = (r_in_op == OP_TRAILER);
    assign advance    = r_in_valid && (!is_trailer || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_op     <= i_in.op;
            r_in_offset <= i_in.seq_offset;
            r_in_len    <= i_in.payload_len;
            r_in_last   <= i_in.last_flag;
            r_in_byte   <= i_in.data_byte;
            r_in_crc    <= i_in.crc_value;
        end
    end

    // trailer checks
    assign fin_crc = ~crc_byte(r_crc, {7'd0, r_hdr_last});
    assign pkt_ok  = (fin_crc == r_in_crc) && (r_hdr_offset == r_expect) &&
                     (r_count == r_hdr_len) && (32'(r_hdr_len) <= MAX_PAYLOAD);

    // next packet state
    always_comb begin
        n_expect     = r_expect;
        n_crc        = r_crc;
        n_hdr_offset = r_hdr_offset;
        n_hdr_len    = r_hdr_len;
        n_hdr_last   = r_hdr_last;
        n_count      = r_count;
        if (advance) begin
            case (r_in_op)
                OP_HEADER: begin
                    n_hdr_offset = r_in_offset;
                    n_hdr_len    = r_in_len;
                    n_hdr_last   = r_in_last;
                    n_crc        = crc_header(r_in_offset, r_in_len);
                    n_count      = '0;
                end
                OP_PAYLOAD: begin
                    n_crc = crc_byte(r_crc, r_in_byte);
                    if (r_count != '1) begin
                        n_count = r_count + LEN_W'(1);
                    end
                end
                OP_TRAILER: begin
                    if (pkt_ok) begin
                        n_expect = r_expect + OFFSET_W'(r_hdr_len);
                    end
                    n_crc   = CRC_INIT;
                    n_count = '0;
                end
                default: begin
                    // unused code: no effect
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect     <= OFFSET_W'(1);
            r_crc        <= CRC_INIT;
            r_hdr_offset <= '0;
            r_hdr_len    <= '0;
            r_hdr_last   <= 1'b0;
            r_count      <= '0;
        end else begin
            r_expect     <= n_expect;
            r_crc        <= n_crc;
            r_hdr_offset <= n_hdr_offset;
            r_hdr_len    <= n_hdr_len;
            r_hdr_last   <= n_hdr_last;
            r_count      <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_trailer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && is_trailer) begin
            r_out_ack  <= n_expect;
            r_out_ok   <= pkt_ok;
            r_out_done <= pkt_ok && r_hdr_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ack_offset    = r_out_ack;
    assign o_out.accepted      = r_out_ok;
    assign o_out.transfer_done = r_out_done;

endmodule

`default_nettype wire

/* hw/rtl/swr_checker.sv */
// port-level checks for the stop-and-wait receiver, bound to the top level
// depends on swr_pkg and stop_wait_receiver_crc32_check_core
`default_nettype none

module swr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [swr_pkg::OFFSET_W-1:0]  i_ack_offset,
    input wire logic                          i_accepted,
    input wire logic                          i_transfer_done
);
    import swr_pkg::*;

    // ack of the last delivered result word
    logic [OFFSET_W-1:0] r_last_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ack <= OFFSET_W'(1);
        end else if (i_out_valid && i_out_ready) begin
            r_last_ack <= i_ack_offset;
        end
    end

    // result register is empty straight after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ack_offset))
        else $error("result word dropped or changed under stall");

    // done only on an accepted packet
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_transfer_done |-> i_accepted)
        else $error("transfer done on a rejected packet");

    // a rejected packet leaves the ack where the last result put it
    a_reject_keeps_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_accepted |-> i_ack_offset == r_last_ack)
        else $error("ack moved on a rejected packet");

endmodule

bind stop_wait_receiver_crc32_check_core swr_checker u_swr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_ack_offset    (o_out.ack_offset),
    .i_accepted      (o_out.accepted),
    .i_transfer_done (o_out.transfer_done)
);

`default_nettype wire

/* tb/sv/stop_wait_receiver_crc32_check_core_tb.sv */
// testbench for the stop-and-wait receiver core with crc-32 packet check
// sends packet words with random gaps and stalls, checks each ack word against a predictor
// depends on swr_pkg, swr_in_if, swr_out_if and stop_wait_receiver_crc32_check_core

module stop_wait_receiver_crc32_check_core_tb;
    import swr_pkg::*;

    localparam int IDLE_MAX       = 11;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 520;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    // op code that the core ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    len;
        logic                last;
        logic [BYTE_W-1:0]   data;
        logic [CRC_W-1:0]    crc;
    } t_word;

    typedef struct {
        logic [OFFSET_W-1:0] ack_offset;
        logic                accepted;
        logic                transfer_done;
    } t_ack;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swr_in_if  in_ch ();
    swr_out_if ack_ch ();

    stop_wait_receiver_crc32_check_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (ack_ch)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver state as the predictor sees it
    logic [OFFSET_W-1:0] rx_count      = '0;
    logic [CRC_W-1:0]    rx_crc        = CRC_INIT;
    logic [OFFSET_W-1:0] rx_hdr_offset = '0;
    logic [LEN_W-1:0]    rx_hdr_len    = '0;
    logic                rx_hdr_last   = 1'b0;
    logic [LEN_W-1:0]    rx_bytes      = '0;

    t_ack ack_q[$];

    int mismatches    = 0;
    int words_sent    = 0;
    int idle_cycles   = 0;
    int in_gap_max    = IDLE_MAX;
    int ack_stall_max = IDLE_MAX;

    // reflected crc-32, one byte lsb first
    function automatic logic [CRC_W-1:0] crc32_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ 32'hEDB8_8320;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // running crc after the offset and length words, little-endian
    function automatic logic [CRC_W-1:0] crc32_header(input logic [OFFSET_W-1:0] offset,
                                                      input logic [LEN_W-1:0] len);
        logic [31:0]      off32;
        logic [31:0]      len32;
        logic [CRC_W-1:0] r;
        off32 = {1'b0, offset};
        len32 = {21'd0, len};
        r     = 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++) begin
            r = crc32_update(r, off32[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            r = crc32_update(r, len32[8*i +: 8]);
        end
        return r;
    endfunction

    // offset the receiver will take next
    function automatic logic [OFFSET_W-1:0] next_offset();
        return OFFSET_W'(rx_count + 1'b1);
    endfunction

    // apply one accepted word to the predicted state, queue the ack it causes
    function automatic void apply_word(input t_word w);
        t_ack a;
        logic ok;
        case (w.op)
            OP_HEADER: begin
                rx_hdr_offset = w.offset;
                rx_hdr_len    = w.len;
                rx_hdr_last   = w.last;
                rx_crc        = crc32_header(w.offset, w.len);
                rx_bytes      = '0;
            end
            OP_PAYLOAD: begin
                rx_crc = crc32_update(rx_crc, w.data);
                if (rx_bytes != '1) begin
                    rx_bytes = rx_bytes + 1'b1;
                end
            end
            OP_TRAILER: begin
                ok = (~crc32_update(rx_crc, {7'd0, rx_hdr_last}) == w.crc) &&
                     (rx_hdr_offset == next_offset()) &&
                     (rx_bytes == rx_hdr_len) &&
                     (rx_hdr_len <= MAX_PAYLOAD);
                if (ok) begin
                    rx_count = rx_count + rx_hdr_len;
                end
                a.ack_offset    = next_offset();
                a.accepted      = ok;
                a.transfer_done = ok && rx_hdr_last;
                ack_q.push_back(a);
                rx_crc   = 32'hFFFF_FFFF;
                rx_bytes = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_word random_word(input logic [OP_W-1:0] op);
        t_word w;
        w.op     = op;
        w.offset = OFFSET_W'($urandom());
        w.len    = LEN_W'($urandom());
        w.last   = 1'($urandom());
        w.data   = BYTE_W'($urandom());
        w.crc    = $urandom();
        return w;
    endfunction

    // drive one word after a random gap, wait for it to be taken
    task automatic send_word(input t_word w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.op          = w.op;
        in_ch.seq_offset  = w.offset;
        in_ch.payload_len = w.len;
        in_ch.last_flag   = w.last;
        in_ch.data_byte   = w.data;
        in_ch.crc_value   = w.crc;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        apply_word(w);
        if (w.op != OP_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic send_header(input logic [OFFSET_W-1:0] offset, input int len,
                               input logic last);
        t_word w;
        w        = random_word(OP_HEADER);
        w.offset = offset;
        w.len    = LEN_W'(len);
        w.last   = last;
        send_word(w);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_word w;
        w      = random_word(OP_PAYLOAD);
        w.data = b;
        send_word(w);
    endtask

    task automatic send_trailer(input logic [CRC_W-1:0] crc);
        t_word w;
        w     = random_word(OP_TRAILER);
        w.crc = crc;
        send_word(w);
    endtask

    // header, nbytes payload bytes, trailer with the true crc xored with crc_flip
    task automatic send_packet(input logic [OFFSET_W-1:0] offset, input int len,
                               input int nbytes, input logic last,
                               input logic [CRC_W-1:0] crc_flip, input logic extremes);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        send_header(offset, len, last);
        crc = crc32_header(offset, LEN_W'(len));
        for (int i = 0; i < nbytes; i++) begin
            b   = extremes ? ((i % 2) ? 8'hFF : 8'h00) : BYTE_W'($urandom());
            crc = crc32_update(crc, b);
            send_byte(b);
        end
        send_trailer(~crc32_update(crc, {7'd0, last}) ^ crc_flip);
    endtask

    // payload and trailer words with no header before them
    task automatic test_stray_words();
        send_trailer('0);
        send_byte(8'h5A);
        send_trailer('1);
    endtask

    // well-formed packets, empty, with extreme bytes, and the final one
    task automatic test_good_packets();
        send_packet(next_offset(), 0, 0, 1'b0, '0, 1'b0);
        send_packet(next_offset(), 2, 2, 1'b0, '0, 1'b1);
        send_packet(next_offset(), 1, 1, 1'b1, '0, 1'b0);
    endtask

    // lone crc, offset, count failures; over-long length; an ignored op; a restarted header
    task automatic test_rejections();
        t_word w;
        send_packet(next_offset(), 0, 0, 1'b0, 32'h0000_0001, 1'b0);
        send_packet('1, 0, 0, 1'b0, '0, 1'b0);
        send_packet(next_offset(), 1, 0, 1'b0, '0, 1'b0);
        w = random_word(OP_UNUSED);
        send_word(w);
        send_packet(next_offset(), 0, 1, 1'b0, '0, 1'b0);
        send_packet(next_offset(), 2047, 0, 1'b1, '0, 1'b0);
        send_header(next_offset(), 5, 1'b1);
        send_packet(next_offset(), 0, 0, 1'b1, '0, 1'b0);
    endtask

    // mostly good packets, with broken packets and noise mixed in
    task automatic test_random_traffic();
        int   start;
        int   kind;
        int   len;
        int   nbytes;
        logic last;
        logic [OFFSET_W-1:0] off;
        t_word w;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            // now and then switch between idling and back-to-back stretches
            if ($urandom_range(0, 7) == 0) begin
                in_gap_max    = $urandom_range(0, 1) ? IDLE_MAX : 0;
                ack_stall_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
            end
            kind = $urandom_range(0, 19);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            last = ($urandom_range(0, 3) == 0);
            case (kind)
                13: send_packet(next_offset(), len, len, last,
                                CRC_W'(1) << $urandom_range(0, CRC_W - 1), 1'b0);
                14: begin
                    off = $urandom_range(0, 1) ? OFFSET_W'($urandom())
                                               : OFFSET_W'(next_offset() + 1'b1);
                    send_packet(off, len, len, last, '0, 1'b0);
                end
                15: begin
                    nbytes = (len == 0 || $urandom_range(0, 1)) ? len + 1 : len - 1;
                    send_packet(next_offset(), len, nbytes, last, '0, 1'b0);
                end
                16: send_packet(OFFSET_W'($urandom()), $urandom_range(0, 2047),
                                $urandom_range(0, 3), last, '0, 1'b0);
                17: begin
                    repeat ($urandom_range(1, 4)) begin
                        w = random_word(OP_W'($urandom_range(0, 3)));
                        send_word(w);
                    end
                end
                18: begin
                    send_header(OFFSET_W'($urandom()), $urandom_range(0, 2047), last);
                    send_packet(next_offset(), len, len, last, '0, 1'b0);
                end
                19: begin
                    repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom()));
                    send_trailer($urandom());
                end
                default: send_packet(next_offset(), len, len, last, '0, 1'b0);
            endcase
        end
    endtask

    // ack sink with a random stall before each word
    initial begin : ack_sink
        int stall;
        ack_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, ack_stall_max);
            if (stall > 0) begin
                ack_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            ack_ch.ready = 1'b1;
            do @(posedge i_clk); while (ack_ch.valid !== 1'b1);
        end
    end

    // compare each ack word with the oldest prediction
    always @(posedge i_clk) begin
        t_ack want;
        if (i_rst_n && ack_ch.valid === 1'b1 && ack_ch.ready === 1'b1) begin
            if (ack_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected ack word: ack_offset %h accepted %b done %b",
                             ack_ch.ack_offset, ack_ch.accepted, ack_ch.transfer_done);
                end
            end else begin
                want = ack_q.pop_front();
                if (ack_ch.ack_offset !== want.ack_offset || ack_ch.accepted !== want.accepted ||
                    ack_ch.transfer_done !== want.transfer_done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ack word wrong: expected %h/%b/%b, got %h/%b/%b",
                                 want.ack_offset, want.accepted, want.transfer_done,
                                 ack_ch.ack_offset, ack_ch.accepted, ack_ch.transfer_done);
                    end
                end
            end
        end
    end

    // cycles since the last word moved on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (ack_ch.valid === 1'b1 && ack_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // reset, tests in turn, drain
    initial begin
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_HEADER;
        in_ch.seq_offset  = '0;
        in_ch.payload_len = '0;
        in_ch.last_flag   = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.crc_value   = '0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_stray_words();
        test_good_packets();
        test_rejections();
        test_random_traffic();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (ack_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
